### hw/rtl/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg: shared definitions for the chain allocator
// Table geometry, link encodings, operation, status and kind codes, and the
// request bundle that drives the link table memory.
// ----------------------------------------------------------------------------
`default_nettype none

package fca_pkg;

    localparam int NUM_BLOCKS       = 2048;
    localparam int ADDR_W           = $clog2(NUM_BLOCKS);
    localparam int CNT_W            = ADDR_W + 1;
    localparam int LINK_W           = 16;
    localparam int FIRST_DATA_BLOCK = 2;
    localparam int RESERVED_BLOCKS  = 2;

    localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;
    localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;

    localparam logic [2:0] OP_FORMAT   = 3'd0;
    localparam logic [2:0] OP_ALLOCATE = 3'd1;
    localparam logic [2:0] OP_EXTEND   = 3'd2;
    localparam logic [2:0] OP_FREE     = 3'd3;
    localparam logic [2:0] OP_FIND     = 3'd4;
    localparam logic [2:0] OP_READ     = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_FREE_LINK = 2'd2;
    localparam logic [1:0] ST_LOOP      = 2'd3;

    localparam logic [1:0] KIND_FREE   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_LINKED = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [LINK_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

### hw/rtl/fca_link_ram.sv
// ----------------------------------------------------------------------------
// fca_link_ram: link table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_link_ram (
    input  wire logic                      i_clk,
    input  wire fca_pkg::t_ram_req         i_req,
    output logic [fca_pkg::LINK_W-1:0]     o_rdata
);
    import fca_pkg::*;

    logic [LINK_W-1:0] r_mem [NUM_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/fat_chain_allocator_core.sv
// ----------------------------------------------------------------------------
// fat_chain_allocator_core: block chain allocator over a link table
// Format, allocate, extend, free chain, find last and read link, all done by
// a small sequencer around one link table memory.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Fields
//  -------  ---------  ---------------------  ---------------------------------
//  in       into core  i_in_valid/o_in_stall  operation, start_block, block_count
//  out      from core  o_out_valid/i_out_stall result_block, freed_count,
//                                             link_kind, status
//
// One beat is in work at a time; the memory port sets the pace. Allocate and
// extend scan the table twice, one entry per cycle (a count pass, then a link
// pass). Free chain and find last walk the chain by reading one link per
// step. Format and the clearing pass after reset sweep the whole table; no
// input beat is taken during the clearing pass. A result waits in the output
// register while the core goes back to idle, so a stalled output only holds
// the core once a second result is ready.
//
`default_nettype none

module fat_chain_allocator_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [2:0]                  i_operation,
    input  wire logic [fca_pkg::ADDR_W-1:0]  i_start_block,
    input  wire logic [fca_pkg::ADDR_W-1:0]  i_block_count,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [fca_pkg::ADDR_W-1:0]       o_result_block,
    output logic [fca_pkg::CNT_W-1:0]        o_freed_count,
    output logic [1:0]                       o_link_kind,
    output logic [1:0]                       o_status
);
    import fca_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CNT   = 4'd2;
    localparam logic [3:0] S_LNK   = 4'd3;
    localparam logic [3:0] S_END   = 4'd4;
    localparam logic [3:0] S_WREQ  = 4'd5;
    localparam logic [3:0] S_WDAT  = 4'd6;
    localparam logic [3:0] S_RDAT  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [CNT_W-1:0] NUM_C   = CNT_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0] FIRST_C = CNT_W'(FIRST_DATA_BLOCK);
    localparam logic [CNT_W-1:0] RSV_C   = CNT_W'(RESERVED_BLOCKS);

    t_ram_req          w_req;
    logic [LINK_W-1:0] w_rdata;

    // Sequencer state.
    logic [3:0]        r_state, n_state;
    logic              r_fmt, n_fmt;
    logic [2:0]        r_op, n_op;
    logic [ADDR_W-1:0] r_s, n_s;
    logic              r_skv, n_skv;
    logic [ADDR_W-1:0] r_need, n_need;
    logic [ADDR_W-1:0] r_got, n_got;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pidx, n_pidx;
    logic [ADDR_W-1:0] r_prev, n_prev;
    logic              r_pv, n_pv;
    logic [ADDR_W-1:0] r_first, n_first;
    logic [ADDR_W-1:0] r_cur, n_cur;
    logic [CNT_W-1:0]  r_steps, n_steps;

    // Result held until the output register is free.
    logic [ADDR_W-1:0] r_res, n_res;
    logic [1:0]        r_kind, n_kind;
    logic [1:0]        r_stat, n_stat;

    // Output register.
    logic              r_ov, n_ov;
    logic [ADDR_W-1:0] r_ores, n_ores;
    logic [CNT_W-1:0]  r_ofreed, n_ofreed;
    logic [1:0]        r_okind, n_okind;
    logic [1:0]        r_ostat, n_ostat;

    logic              w_cand;
    logic              w_issue;
    logic              w_accept;

    fca_link_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign w_accept       = i_in_valid && !o_in_stall;
    assign o_out_valid    = r_ov;
    assign o_result_block = r_ores;
    assign o_freed_count  = r_ofreed;
    assign o_link_kind    = r_okind;
    assign o_status       = r_ostat;

    // A scanned entry is a candidate when it is free and is not the block
    // being extended.
    assign w_cand  = r_pend && (w_rdata == LINK_FREE) && !(r_skv && (r_pidx == r_s));
    assign w_issue = (r_idx < NUM_C);

    always_comb begin
        n_state  = r_state;
        n_fmt    = r_fmt;
        n_op     = r_op;
        n_s      = r_s;
        n_skv    = r_skv;
        n_need   = r_need;
        n_got    = r_got;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_prev   = r_prev;
        n_pv     = r_pv;
        n_first  = r_first;
        n_cur    = r_cur;
        n_steps  = r_steps;
        n_res    = r_res;
        n_kind   = r_kind;
        n_stat   = r_stat;
        n_ov     = r_ov;
        n_ores   = r_ores;
        n_ofreed = r_ofreed;
        n_okind  = r_okind;
        n_ostat  = r_ostat;

        w_req.we    = 1'b0;
        w_req.waddr = r_prev;
        w_req.wdata = LINK_END;
        w_req.raddr = r_idx[ADDR_W-1:0];

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // Sweep the whole table: reserved blocks end, others free.
                w_req.we    = 1'b1;
                w_req.waddr = r_idx[ADDR_W-1:0];
                w_req.wdata = (r_idx < RSV_C) ? LINK_END : LINK_FREE;
                n_idx       = r_idx + CNT_W'(1);
                if (r_idx == NUM_C - CNT_W'(1)) begin
                    n_state = r_fmt ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                w_req.raddr = i_start_block;
                if (w_accept) begin
                    n_op    = i_operation;
                    n_s     = i_start_block;
                    n_cur   = i_start_block;
                    n_res   = '0;
                    n_kind  = KIND_FREE;
                    n_stat  = ST_OK;
                    n_steps = '0;
                    n_got   = '0;
                    n_pend  = 1'b0;
                    n_idx   = FIRST_C;
                    n_first = '0;
                    unique case (i_operation) inside
                        OP_FORMAT: begin
                            n_fmt   = 1'b1;
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        OP_ALLOCATE: begin
                            n_need  = (i_block_count == '0) ? ADDR_W'(1) : i_block_count;
                            n_skv   = 1'b0;
                            n_pv    = 1'b0;
                            n_state = S_CNT;
                        end
                        OP_EXTEND: begin
                            n_skv  = 1'b1;
                            n_pv   = 1'b1;
                            n_prev = i_start_block;
                            if (i_block_count <= ADDR_W'(1)) begin
                                n_need  = '0;
                                n_state = S_END;
                            end else begin
                                n_need  = i_block_count - ADDR_W'(1);
                                n_state = S_CNT;
                            end
                        end
                        OP_FREE, OP_FIND: begin
                            n_state = S_WDAT;
                        end
                        OP_READ: begin
                            n_state = S_RDAT;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CNT: begin
                // Count pass: stop as soon as enough candidates are seen.
                if (w_cand && (r_got + ADDR_W'(1) == r_need)) begin
                    n_state = S_LNK;
                    n_idx   = FIRST_C;
                    n_pend  = 1'b0;
                    n_got   = '0;
                end else if (!r_pend && !w_issue) begin
                    n_stat  = ST_NO_SPACE;
                    n_state = S_DONE;
                end else begin
                    if (w_cand) begin
                        n_got = r_got + ADDR_W'(1);
                    end
                    n_pend = w_issue;
                    n_pidx = r_idx[ADDR_W-1:0];
                    if (w_issue) begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            S_LNK: begin
                // Link pass: each candidate is linked behind the previous one.
                n_pend = w_issue;
                n_pidx = r_idx[ADDR_W-1:0];
                if (w_issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (w_cand) begin
                    w_req.we    = r_pv;
                    w_req.waddr = r_prev;
                    w_req.wdata = LINK_W'(r_pidx);
                    if (r_got == '0) begin
                        n_first = r_pidx;
                    end
                    n_prev = r_pidx;
                    n_pv   = 1'b1;
                    n_got  = r_got + ADDR_W'(1);
                    if (r_got + ADDR_W'(1) == r_need) begin
                        n_state = S_END;
                    end
                end
            end
            S_END: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_prev;
                w_req.wdata = LINK_END;
                n_res       = (r_op == OP_EXTEND) ? r_s : r_first;
                n_state     = S_DONE;
            end
            S_WREQ: begin
                w_req.raddr = r_cur;
                n_state     = S_WDAT;
            end
            S_WDAT: begin
                // A free entry means a bad start or a link into a free block;
                // the step limit is checked only after that.
                if (w_rdata == LINK_FREE) begin
                    n_stat  = ST_FREE_LINK;
                    n_state = S_DONE;
                end else if (r_steps == NUM_C) begin
                    n_stat  = ST_LOOP;
                    n_state = S_DONE;
                end else if (r_op == OP_FREE) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_cur;
                    w_req.wdata = LINK_FREE;
                    n_steps     = r_steps + CNT_W'(1);
                    if (w_rdata == LINK_END) begin
                        n_state = S_DONE;
                    end else if (w_rdata[LINK_W-1:ADDR_W] != '0) begin
                        n_stat  = ST_FREE_LINK;
                        n_state = S_DONE;
                    end else begin
                        n_cur   = w_rdata[ADDR_W-1:0];
                        n_state = S_WREQ;
                    end
                end else begin
                    if (w_rdata == LINK_END) begin
                        n_res   = r_cur;
                        n_state = S_DONE;
                    end else if (w_rdata[LINK_W-1:ADDR_W] != '0) begin
                        n_stat  = ST_FREE_LINK;
                        n_state = S_DONE;
                    end else begin
                        n_cur   = w_rdata[ADDR_W-1:0];
                        n_steps = r_steps + CNT_W'(1);
                        n_state = S_WREQ;
                    end
                end
            end
            S_RDAT: begin
                if (w_rdata == LINK_END) begin
                    n_kind = KIND_END;
                end else if (w_rdata != LINK_FREE) begin
                    n_kind = KIND_LINKED;
                    n_res  = w_rdata[ADDR_W-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov     = 1'b1;
                    n_ores   = r_res;
                    n_ofreed = (r_op == OP_FREE) ? r_steps : '0;
                    n_okind  = r_kind;
                    n_ostat  = r_stat;
                    if (r_fmt) begin
                        n_ores   = '0;
                        n_ofreed = '0;
                        n_okind  = KIND_FREE;
                        n_ostat  = ST_OK;
                    end
                    n_fmt   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_fmt   <= 1'b0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fmt   <= n_fmt;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_s      <= n_s;
        r_skv    <= n_skv;
        r_need   <= n_need;
        r_got    <= n_got;
        r_pidx   <= n_pidx;
        r_prev   <= n_prev;
        r_pv     <= n_pv;
        r_first  <= n_first;
        r_cur    <= n_cur;
        r_steps  <= n_steps;
        r_res    <= n_res;
        r_kind   <= n_kind;
        r_stat   <= n_stat;
        r_ores   <= n_ores;
        r_ofreed <= n_ofreed;
        r_okind  <= n_okind;
        r_ostat  <= n_ostat;
    end

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the block chain allocator core
// A shadow link table predicts every result. Beats enter through a clocked
// driver fed from a queue, and a clocked monitor checks each result beat
// against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import fca_pkg::*;

    typedef struct {
        logic [2:0]        op;
        logic [ADDR_W-1:0] sblk;
        logic [ADDR_W-1:0] cnt;
    } t_req;

    typedef struct {
        logic [ADDR_W-1:0] blk;
        logic [CNT_W-1:0]  freed;
        logic [1:0]        kind;
        logic [1:0]        st;
    } t_rsp;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [2:0]        operation = '0;
    logic [ADDR_W-1:0] start_block = '0;
    logic [ADDR_W-1:0] block_count = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [ADDR_W-1:0] result_block;
    logic [CNT_W-1:0]  freed_count;
    logic [1:0]        link_kind;
    logic [1:0]        status;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    int   cycle = 0;
    logic [LINK_W-1:0] shadow_links[NUM_BLOCKS];
    int   chain_heads[$];

    fat_chain_allocator_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_operation(operation), .i_start_block(start_block),
        .i_block_count(block_count),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_result_block(result_block), .o_freed_count(freed_count),
        .o_link_kind(link_kind), .o_status(status)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idling is switched off in a long window so back-to-back beats occur.
    function automatic bit idle_now();
        if (cycle > 30000 && cycle < 150000) return 1'b0;
        return $urandom_range(99) < 7;
    endfunction

    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle > 40_000_000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (pending_reqs.size() > 0 && !idle_now()) begin
                in_valid    <= 1'b1;
                operation   <= pending_reqs[0].op;
                start_block <= pending_reqs[0].sblk;
                block_count <= pending_reqs[0].cnt;
                void'(pending_reqs.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) out_stall <= idle_now();
    end

    always @(posedge clk) begin
        t_rsp e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected result beat blk=%0d freed=%0d kind=%0d st=%0d",
                         $time, result_block, freed_count, link_kind, status);
                errors <= errors + 1;
            end else begin
                e = expected_rsps.pop_front();
                if (e.blk !== result_block || e.freed !== freed_count ||
                    e.kind !== link_kind || e.st !== status) begin
                    $display("%0t: expected blk=%0d freed=%0d kind=%0d st=%0d, got blk=%0d freed=%0d kind=%0d st=%0d",
                             $time, e.blk, e.freed, e.kind, e.st,
                             result_block, freed_count, link_kind, status);
                    errors <= errors + 1;
                end
            end
        end
    end

    function automatic void shadow_format();
        for (int i = 0; i < NUM_BLOCKS; i++) shadow_links[i] = LINK_FREE;
        shadow_links[0] = LINK_END;
        shadow_links[1] = LINK_END;
    endfunction

    function automatic bit bool_free(int b, int skip);
        return b != skip && shadow_links[b] == LINK_FREE;
    endfunction

    function automatic int count_avail(int need, int skip);
        int got = 0;
        for (int i = FIRST_DATA_BLOCK; i < NUM_BLOCKS && got < need; i++)
            if (bool_free(i, skip)) got++;
        return got;
    endfunction

    // Links need free blocks behind prev (prev < 0 starts a new chain).
    function automatic int take_blocks(int prev, int need, int skip);
        int first = 0;
        int got = 0;
        for (int i = FIRST_DATA_BLOCK; i < NUM_BLOCKS && got < need; i++) begin
            if (bool_free(i, skip)) begin
                if (prev >= 0) shadow_links[prev] = i[LINK_W-1:0];
                if (got == 0) first = i;
                prev = i;
                got++;
            end
        end
        if (prev >= 0) shadow_links[prev] = LINK_END;
        return first;
    endfunction

    function automatic bit broken_next(int v);
        return v >= NUM_BLOCKS || shadow_links[v] == LINK_FREE;
    endfunction

    function automatic t_rsp predict_chain_op(t_req r);
        t_rsp o = '{default: '0};
        int s = r.sblk;
        int n = r.cnt;
        int need, cur, v, steps, freed;
        case (r.op)
            OP_FORMAT: shadow_format();
            OP_ALLOCATE: begin
                need = (n == 0) ? 1 : n;
                if (count_avail(need, -1) < need) o.st = ST_NO_SPACE;
                else o.blk = ADDR_W'(take_blocks(-1, need, -1));
            end
            OP_EXTEND: begin
                need = (n == 0) ? 0 : n - 1;
                if (count_avail(need, s) < need) o.st = ST_NO_SPACE;
                else begin
                    void'(take_blocks(s, need, s));
                    o.blk = ADDR_W'(s);
                end
            end
            OP_FREE: begin
                if (shadow_links[s] == LINK_FREE) o.st = ST_FREE_LINK;
                else begin
                    cur = s;
                    freed = 0;
                    forever begin
                        v = shadow_links[cur];
                        shadow_links[cur] = LINK_FREE;
                        freed++;
                        if (v == LINK_END) break;
                        if (broken_next(v)) begin
                            o.st = ST_FREE_LINK;
                            break;
                        end
                        if (freed >= NUM_BLOCKS) begin
                            o.st = ST_LOOP;
                            break;
                        end
                        cur = v;
                    end
                    o.freed = CNT_W'(freed);
                end
            end
            OP_FIND: begin
                if (shadow_links[s] == LINK_FREE) o.st = ST_FREE_LINK;
                else begin
                    cur = s;
                    steps = 0;
                    while (shadow_links[cur] != LINK_END) begin
                        v = shadow_links[cur];
                        if (broken_next(v)) begin
                            o.st = ST_FREE_LINK;
                            break;
                        end
                        cur = v;
                        steps++;
                        if (steps >= NUM_BLOCKS) begin
                            o.st = ST_LOOP;
                            break;
                        end
                    end
                    if (o.st == ST_OK) o.blk = ADDR_W'(cur);
                end
            end
            OP_READ: begin
                v = shadow_links[s];
                if (v == LINK_END) o.kind = KIND_END;
                else if (v != LINK_FREE) begin
                    o.kind = KIND_LINKED;
                    o.blk = v[ADDR_W-1:0];
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // Queues a beat and its prediction; the core handles beats in order.
    task automatic queue_beat(logic [2:0] op, int s, int n);
        t_req r;
        t_rsp o;
        r.op = op;
        r.sblk = ADDR_W'(s);
        r.cnt = ADDR_W'(n);
        o = predict_chain_op(r);
        if (op == OP_FORMAT) chain_heads.delete();
        if (op == OP_ALLOCATE && o.st == ST_OK)
            chain_heads.insert(chain_heads.size(), int'(o.blk));
        pending_reqs.insert(pending_reqs.size(), r);
        expected_rsps.insert(expected_rsps.size(), o);
    endtask

    function automatic int pick_start();
        if (chain_heads.size() > 0 && $urandom_range(99) < 75)
            return chain_heads[$urandom_range(chain_heads.size() - 1)];
        if ($urandom_range(3) == 0) return $urandom_range(NUM_BLOCKS - 1);
        return $urandom_range(63);
    endfunction

    initial begin
        int pick, s, idx;
        shadow_format();

        // Directed part: reserved blocks, zero counts, no space, free starts.
        queue_beat(OP_READ, 0, 0);
        queue_beat(OP_READ, 1, 2047);
        queue_beat(OP_READ, 2047, 0);
        queue_beat(OP_FREE, 5, 0);
        queue_beat(OP_FIND, 2047, 0);
        queue_beat(OP_ALLOCATE, 0, 0);
        queue_beat(OP_ALLOCATE, 0, 3);
        queue_beat(OP_READ, 3, 0);
        queue_beat(OP_FIND, 3, 0);
        queue_beat(OP_EXTEND, 2, 0);
        queue_beat(OP_EXTEND, 4, 1);
        queue_beat(OP_EXTEND, 100, 4);
        queue_beat(OP_FIND, 3, 0);
        queue_beat(OP_FREE, 3, 0);
        queue_beat(OP_FIND, 100, 0);
        queue_beat(OP_ALLOCATE, 0, 2047);
        queue_beat(OP_FORMAT, 0, 0);
        queue_beat(OP_ALLOCATE, 2047, 2046);
        queue_beat(OP_ALLOCATE, 0, 1);
        queue_beat(OP_EXTEND, 1, 2047);
        queue_beat(OP_FIND, 2, 0);
        queue_beat(OP_FREE, 2, 0);
        queue_beat(6, 2047, 2047);
        queue_beat(7, 0, 0);
        chain_heads.delete();

        // Random part: mostly chain work on live heads, some noise.
        for (int k = 0; k < 266; k++) begin
            pick = $urandom_range(99);
            s = pick_start();
            if (pick < 33) begin
                queue_beat(OP_ALLOCATE, $urandom_range(NUM_BLOCKS - 1),
                           ($urandom_range(19) == 0) ? $urandom_range(NUM_BLOCKS - 1)
                                                     : $urandom_range(12));
            end else if (pick < 48) begin
                queue_beat(OP_EXTEND, s, ($urandom_range(29) == 0) ?
                           $urandom_range(NUM_BLOCKS - 1) : $urandom_range(8));
            end else if (pick < 64) begin
                if (chain_heads.size() > 0 && $urandom_range(3) != 0) begin
                    idx = $urandom_range(chain_heads.size() - 1);
                    s = chain_heads[idx];
                    chain_heads.delete(idx);
                end
                queue_beat(OP_FREE, s, $urandom_range(NUM_BLOCKS - 1));
            end else if (pick < 80) begin
                queue_beat(OP_FIND, s, $urandom_range(NUM_BLOCKS - 1));
            end else if (pick < 96) begin
                queue_beat(OP_READ, ($urandom_range(1) == 0) ? s : $urandom_range(40),
                           $urandom_range(NUM_BLOCKS - 1));
            end else if (pick < 98) begin
                queue_beat(OP_FORMAT, $urandom_range(NUM_BLOCKS - 1),
                           $urandom_range(NUM_BLOCKS - 1));
            end else begin
                queue_beat($urandom_range(7, 6), $urandom_range(NUM_BLOCKS - 1),
                           $urandom_range(NUM_BLOCKS - 1));
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (5000) @(posedge clk);
        if (errors == 0 && expected_rsps.size() == 0 && !out_valid)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/fca_pkg.sv
hw/rtl/fca_link_ram.sv
hw/rtl/fat_chain_allocator_core.sv
tb/tb.sv
